[sv/ifre_pkg.sv]
// Shared constants, types and helpers for the image flip/rotate engine.
`default_nettype none

package ifre_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIXEL_BITS  = 24;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int PIX_FIELD_W = 24;
  localparam int CFG_MODE_W  = 3;
  localparam int CFG_SIZE_W  = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIMW_W = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W  = (DIMW_W > DIMH_W) ? DIMW_W : DIMH_W;
  localparam int WIDE_W = 2 * DIM_W;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = CFG_SIZE_W'(256);

  typedef enum logic [CFG_MODE_W-1:0] {
    MODE_VFLIP   = 3'd0,
    MODE_HFLIP   = 3'd1,
    MODE_ROT_CW  = 3'd2,
    MODE_ROT_180 = 3'd3,
    MODE_ROT_CCW = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_SIZE_W-1:0] v,
                                                 input int max_v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > 32'(max_v)) begin
      res = DIM_W'(max_v);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/ifre_in_if.sv]
// Input item channel: command and source pixel.
`default_nettype none

interface ifre_in_if import ifre_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [PIX_FIELD_W-1:0] pixel_in;

  modport source (output valid, output command, output pixel_in, input ready);
  modport sink   (input valid, input command, input pixel_in, output ready);
endinterface

`default_nettype wire

[sv/ifre_out_if.sv]
// Result item channel: transformed pixel and end-of-frame flag.
`default_nettype none

interface ifre_out_if import ifre_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PIX_FIELD_W-1:0] pixel_out;
  logic                   last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

`default_nettype wire

[sv/ifre_cfg_if.sv]
// Configuration write channel: register index and write data.
`default_nettype none

interface ifre_cfg_if import ifre_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

`default_nettype wire

[sv/ifre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ifre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/ifre_front.sv]
// Front end: config registers, item intake, load/fetch position tracking and address mapping.
`default_nettype none

module ifre_front import ifre_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ifre_in_if.sink      in_if,
  ifre_cfg_if.sink     cfg_if,
  input  wire q_stat_t q_stat,
  output      logic    push,
  output      cmd_t    push_cmd
);

  logic [CFG_MODE_W-1:0] mode_r;
  logic [CFG_SIZE_W-1:0] width_r;
  logic [CFG_SIZE_W-1:0] height_r;
  logic [ADDR_W-1:0]     load_pos_r, load_pos_nxt;
  logic [IDX_W-1:0]      row_r, row_nxt;
  logic [IDX_W-1:0]      col_r, col_nxt;

  logic [DIM_W-1:0]  w, h, out_cols, out_rows, sr, sc, c_inc, r_inc;
  logic [WIDE_W-1:0] total, lp_inc, map_addr;
  logic [ADDR_W-1:0] lp_cur;
  logic [IDX_W-1:0]  r, c;
  logic              swap, wrap, last;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !q_stat.full;
  assign push         = in_if.valid && in_if.ready;

  always_comb begin
    w     = clamp_dim(width_r, MAX_WIDTH);
    h     = clamp_dim(height_r, MAX_HEIGHT);
    total = WIDE_W'(w) * WIDE_W'(h);

    lp_cur = (WIDE_W'(load_pos_r) >= total) ? '0 : load_pos_r;
    lp_inc = WIDE_W'(lp_cur) + WIDE_W'(1);

    swap     = (mode_t'(mode_r) == MODE_ROT_CW) || (mode_t'(mode_r) == MODE_ROT_CCW);
    out_cols = swap ? h : w;
    out_rows = swap ? w : h;
    wrap     = (DIM_W'(row_r) >= out_rows) || (DIM_W'(col_r) >= out_cols);
    r        = wrap ? '0 : row_r;
    c        = wrap ? '0 : col_r;

    unique case (mode_t'(mode_r))
      MODE_HFLIP: begin
        sr = DIM_W'(r);
        sc = w - DIM_W'(1) - DIM_W'(c);
      end
      MODE_ROT_CW: begin
        sr = h - DIM_W'(1) - DIM_W'(c);
        sc = DIM_W'(r);
      end
      MODE_ROT_180: begin
        sr = h - DIM_W'(1) - DIM_W'(r);
        sc = w - DIM_W'(1) - DIM_W'(c);
      end
      MODE_ROT_CCW: begin
        sr = DIM_W'(c);
        sc = w - DIM_W'(1) - DIM_W'(r);
      end
      default: begin
        sr = h - DIM_W'(1) - DIM_W'(r);
        sc = DIM_W'(c);
      end
    endcase

    map_addr = WIDE_W'(sr) * WIDE_W'(w) + WIDE_W'(sc);
    last     = (DIM_W'(r) == out_rows - DIM_W'(1)) && (DIM_W'(c) == out_cols - DIM_W'(1));
    c_inc    = DIM_W'(c) + DIM_W'(1);
    r_inc    = DIM_W'(r) + DIM_W'(1);
  end

  always_comb begin
    load_pos_nxt = load_pos_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (push && in_if.command == OP_LOAD) begin
      load_pos_nxt = (lp_inc >= total) ? '0 : ADDR_W'(lp_inc);
    end
    if (push && in_if.command == OP_FETCH) begin
      if (c_inc >= out_cols) begin
        col_nxt = '0;
        row_nxt = (r_inc >= out_rows) ? '0 : IDX_W'(r_inc);
      end else begin
        col_nxt = IDX_W'(c_inc);
        row_nxt = r;
      end
    end
  end

  always_comb begin
    push_cmd.op    = op_t'(in_if.command);
    push_cmd.pixel = PIXEL_BITS'(in_if.pixel_in);
    push_cmd.addr  = (in_if.command == OP_FETCH) ? ADDR_W'(map_addr) : lp_cur;
    push_cmd.last  = (in_if.command == OP_FETCH) && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_VFLIP;
      width_r    <= SIZE_RESET;
      height_r   <= SIZE_RESET;
      load_pos_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        unique case (cfg_reg_t'(cfg_if.wr_index))
          CFG_MODE:   mode_r   <= CFG_MODE_W'(cfg_if.wr_data);
          CFG_WIDTH:  width_r  <= CFG_SIZE_W'(cfg_if.wr_data);
          CFG_HEIGHT: height_r <= CFG_SIZE_W'(cfg_if.wr_data);
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[sv/ifre_queue.sv]
// Short command queue between the front end and the back end.
`default_nettype none

module ifre_queue import ifre_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire cmd_t    push_cmd,
  input  wire logic    pop,
  output      cmd_t    head,
  output      q_stat_t stat
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head       = entries_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/ifre_back.sv]
// Back end: frame store writes and reads, read stage and output register.
`default_nettype none

module ifre_back import ifre_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_stat_t q_stat,
  input  wire cmd_t    head,
  output      logic    pop,
  ifre_out_if.source   out_if
);

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_last_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [PIX_FIELD_W-1:0] out_pixel_r;
  logic                   out_last_r;
  logic [PIXEL_BITS-1:0]  rd_data;
  logic                   is_fetch, s1_adv, issue_ok, we, re;

  always_comb begin
    is_fetch = (head.op == OP_FETCH);
    s1_adv   = s1_valid_r && (!out_valid_r || out_if.ready);
    issue_ok = !s1_valid_r || s1_adv;
    pop      = !q_stat.empty && (!is_fetch || issue_ok);
    we       = pop && !is_fetch;
    re       = pop && is_fetch;

    s1_valid_nxt = s1_valid_r;
    if (re) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  ifre_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (we),
    .waddr (head.addr),
    .wdata (head.pixel),
    .re    (re),
    .raddr (head.addr),
    .rdata (rd_data)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.pixel_out  = out_pixel_r;
  assign out_if.last_pixel = out_last_r;

  always_ff @(posedge clk) begin
    if (re) begin
      s1_last_r <= head.last;
    end
    if (s1_adv) begin
      out_pixel_r <= PIX_FIELD_W'(rd_data);
      out_last_r  <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/image_flip_rotate_engine_unit.sv]
// Top level of the image flip/rotate engine: front end, command queue, back end.
// Throughput: one item (load or fetch) per cycle while the result side takes items.
// Path: a fetched pixel passes through the queue, the RAM read and the output register
// in that order before it is presented.
// The single-port-pair frame store sets the rate: one write or one read per cycle.
// Reset: mode vertical flip, size 256x256, load/fetch positions zero; frame store not cleared.
`default_nettype none

module image_flip_rotate_engine_unit import ifre_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  ifre_in_if.sink     in_if,
  ifre_out_if.source  out_if,
  ifre_cfg_if.sink    cfg_if
);

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  ifre_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ifre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ifre_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> q_stat.count ==
      QCNT_W'($past(q_stat.count) + QCNT_W'($past(push)) - QCNT_W'($past(pop))))
    else $error("queue count out of step with push/pop");

endmodule

`default_nettype wire
